// File: rtl/sstw_pkg.sv
// Shared types, register indexes and constants for the stroke speed to width block.
package sstw_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_FLOOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_CEIL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_DB = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH = 3'd7;

  localparam logic [19:0] RAW_SPEED_SAT = 20'hFFFFF;
  localparam logic [15:0] US_PER_SEC_16 = 16'd62500;

  typedef struct packed {
    logic [15:0] speed_min;
    logic [15:0] speed_max;
    logic [19:0] step_min;
    logic [19:0] step_max;
    logic [11:0] width_floor;
    logic [11:0] width_ceiling;
    logic [11:0] width_deadband;
    logic [7:0]  growth_gain;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        first;
    logic        second;
    logic [16:0] dx;
    logic [16:0] dy;
    logic [19:0] step;
  } job_t;

  localparam int JOB_W = $bits(job_t);

endpackage

// File: rtl/stroke_speed_to_width_core.sv
// Top level: stroke width from touch point speed.
//  channel | dir | handshake              | payload
//  in      | in  | in_tvalid / in_tready  | tdata {time_us, pos_y, pos_x}, tuser stroke_start
//  out     | out | out_tvalid / out_tready| tdata {width, speed, raw_speed}
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
// A first point of a stroke goes from idle straight to the output register; any other point
// passes the 17-step square root, a multiply, the 34-step divider, the filter and the width
// states in the back end first. The back end takes no new point until it is done.
// Reset is synchronous, active low, and restores the register defaults.
// The front accepts while the two-entry queue has room; the output register holds under stall.
module stroke_speed_to_width_core
  import sstw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,   // pos_x[15:0], pos_y[31:16], time_us[63:32]
  input  logic                  in_tuser,   // stroke_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,  // raw_speed[19:0], speed[35:20], width[47:36]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  logic        fj_valid, fj_ready, bj_valid, bj_ready;
  job_t        fj, bj;
  logic [19:0] raw_speed;
  logic [15:0] speed;
  logic [11:0] width;

  assign cfg_ready = 1'b1;

  sstw_cfg u_cfg (
    .clk, .rst_n, .wr_en(cfg_valid), .wr_idx(cfg_index), .wr_data(cfg_data), .cfg
  );

  sstw_front u_front (
    .clk, .rst_n, .cfg,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .pos_x(in_tdata[15:0]), .pos_y(in_tdata[31:16]), .time_us(in_tdata[63:32]),
    .stroke_start(in_tuser),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  sstw_fifo u_fifo (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  sstw_back u_back (
    .clk, .rst_n, .cfg, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .raw_speed, .speed, .width
  );

  assign out_tdata = {width, speed, raw_speed};

endmodule

// File: rtl/sstw_cfg.sv
// Configuration register file with reset values.
module sstw_cfg
  import sstw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_idx,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_min      <= 16'd100;
      cfg_r.speed_max      <= 16'd3000;
      cfg_r.step_min       <= 20'd5000;
      cfg_r.step_max       <= 20'd20000;
      cfg_r.width_floor    <= 12'd64;
      cfg_r.width_ceiling  <= 12'd2560;
      cfg_r.width_deadband <= 12'd64;
      cfg_r.growth_gain    <= 8'd26;
    end else if (wr_en) begin
      case (wr_idx)
        REG_SPEED_MIN:   cfg_r.speed_min      <= wr_data[15:0];
        REG_SPEED_MAX:   cfg_r.speed_max      <= wr_data[15:0];
        REG_STEP_MIN:    cfg_r.step_min       <= wr_data;
        REG_STEP_MAX:    cfg_r.step_max       <= wr_data;
        REG_WIDTH_FLOOR: cfg_r.width_floor    <= wr_data[11:0];
        REG_WIDTH_CEIL:  cfg_r.width_ceiling  <= wr_data[11:0];
        REG_WIDTH_DB:    cfg_r.width_deadband <= wr_data[11:0];
        REG_GROWTH:      cfg_r.growth_gain    <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/sstw_front.sv
// Front end: accepts points, keeps the last point, classifies and clamps the time step.
module sstw_front
  import sstw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [31:0] time_us,
  input  logic        stroke_start,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  logic [15:0] last_x_r, last_y_r;
  logic [31:0] last_time_r;
  logic [1:0]  seen_r;
  logic        acc;
  logic [31:0] d;
  logic [19:0] s1, s2;
  logic        first;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign acc       = in_valid && in_ready;
  assign first     = stroke_start || (seen_r == 2'd0);
  assign d         = time_us - last_time_r;

  always_comb begin
    if (d == 32'd0 || d[31] || d < {12'd0, cfg.step_min}) s1 = cfg.step_min;
    else if (d > {12'd0, cfg.step_max}) s1 = cfg.step_max;
    else s1 = d[19:0];
    s2 = (s1 > cfg.step_max) ? cfg.step_max : s1;
    job.first  = first;
    job.second = !first && (seen_r == 2'd1);
    job.dx     = {pos_x[15], pos_x} - {last_x_r[15], last_x_r};
    job.dy     = {pos_y[15], pos_y} - {last_y_r[15], last_y_r};
    job.step   = (s2 == 20'd0) ? 20'd1 : s2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_time_r <= '0;
      seen_r      <= '0;
    end else if (acc) begin
      last_x_r    <= pos_x;
      last_y_r    <= pos_y;
      last_time_r <= time_us;
      seen_r      <= first ? 2'd1 : 2'd2;
    end
  end

endmodule

// File: rtl/sstw_fifo.sv
// Two-entry request queue between front and back.
module sstw_fifo
  import sstw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overfilled");
  a_no_wr_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !wr) else $error("write into full queue");
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && wr) |=> cnt_r == 2'd1) else $error("count lost");

endmodule

// File: rtl/sstw_back.sv
// Back end: square root, division, median, clamps and width tracking, with output register.
module sstw_back
  import sstw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] raw_speed,
  output logic [15:0] speed,
  output logic [11:0] width
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQRT = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FILT = 3'd4;
  localparam logic [2:0] S_WID  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // ceil(2^27 / 25): exact floor of n / 25 for every n below 2^22
  localparam logic [22:0] EST_RECIP = 23'd5368710;

  logic [2:0]  st_r, st_nxt;
  logic [5:0]  cnt_r;
  logic [33:0] rem_r;       // sqrt: remaining radicand
  logic [17:0] root_r;
  logic [33:0] sq_r;
  logic [33:0] prod_r;      // dist * 62500, at most 2^34
  logic [53:0] div_r;       // {remainder, quotient}
  logic [19:0] step_r;
  logic        second_r;
  logic [19:0] raw_r, prev_r, prev2_r;
  logic [15:0] spd_r;
  logic [11:0] cur_w_r;
  logic [11:0] est_r;
  logic [19:0] o_raw_r;
  logic [15:0] o_spd_r;
  logic [11:0] o_w_r;
  logic        o_valid_r;

  logic [16:0] adx, ady;
  logic [20:0] dpart;
  logic [19:0] q, m, a, b, c;
  logic [19:0] f1;
  logic [15:0] f2;
  logic [38:0] e_prod;
  logic [21:0] e_full;
  logic [11:0] e1, e2;
  logic [12:0] err;
  logic [11:0] mag;
  logic [19:0] stepw;
  logic [12:0] wsum;
  logic [11:0] w0, w1, w2;

  assign adx = job.dx[16] ? -job.dx : job.dx;
  assign ady = job.dy[16] ? -job.dy : job.dy;

  assign dpart = {div_r[53:34], prod_r[33]};

  always_comb begin
    q = (div_r[33:0] > {14'd0, RAW_SPEED_SAT}) ? RAW_SPEED_SAT : div_r[19:0];
    a = q;
    b = second_r ? q : prev_r;
    c = second_r ? prev_r : prev2_r;
    if ((a >= b && a <= c) || (a >= c && a <= b)) m = a;
    else if ((b >= a && b <= c) || (b >= c && b <= a)) m = b;
    else m = c;
    f1 = (m < {4'd0, cfg.speed_min}) ? {4'd0, cfg.speed_min} : m;
    f2 = (f1 > {4'd0, cfg.speed_max}) ? cfg.speed_max : f1[15:0];
    e_prod = {16'd0, EST_RECIP} * {23'd0, spd_r};
    e_full = {4'd0, e_prod[38:21]};
    e1 = (e_full < {10'd0, cfg.width_floor}) ? cfg.width_floor :
         ((e_full > 22'd4095) ? 12'hFFF : e_full[11:0]);
    e2 = (e1 > cfg.width_ceiling) ? cfg.width_ceiling : e1;
    err = {1'b0, est_r} - {1'b0, cur_w_r};
    mag = err[12] ? 12'(-err) : err[11:0];
    stepw = ({8'd0, mag} * {12'd0, cfg.growth_gain}) >> 8;
    wsum = {1'b0, cur_w_r} + stepw[12:0];
    w0 = cur_w_r;
    if (mag > cfg.width_deadband) begin
      if (err[12]) w0 = (stepw[11:0] > cur_w_r) ? 12'd0 : cur_w_r - stepw[11:0];
      else w0 = wsum[11:0];
    end
    w1 = (w0 < cfg.width_floor) ? cfg.width_floor : w0;
    w2 = (w1 > cfg.width_ceiling) ? cfg.width_ceiling : w1;
  end

  assign job_ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (job_valid) st_nxt = job.first ? S_DONE : S_SQRT;
      S_SQRT: if (cnt_r == 6'd16) st_nxt = S_MUL;
      S_MUL:  st_nxt = S_DIV;
      S_DIV:  if (cnt_r == 6'd33) st_nxt = S_FILT;
      S_FILT: st_nxt = S_WID;
      S_WID:  st_nxt = S_DONE;
      S_DONE: if (!o_valid_r || out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // job capture, restoring square root (one result bit per cycle), multiply, divide and filter
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (job_valid) begin
        sq_r     <= {17'd0, adx} * {17'd0, adx} + {17'd0, ady} * {17'd0, ady};
        rem_r    <= '0;
        root_r   <= '0;
        step_r   <= job.step;
        second_r <= job.second;
        if (job.first) begin
          raw_r   <= '0;
          spd_r   <= '0;
          prev_r  <= '0;
          prev2_r <= '0;
        end
      end
      S_SQRT: begin
        if ({rem_r[31:0], sq_r[33:32]} >= {15'd0, root_r[16:0], 2'b01}) begin
          rem_r  <= {rem_r[31:0], sq_r[33:32]} - {15'd0, root_r[16:0], 2'b01};
          root_r <= {root_r[16:0], 1'b1};
        end else begin
          rem_r  <= {rem_r[31:0], sq_r[33:32]};
          root_r <= {root_r[16:0], 1'b0};
        end
        sq_r <= {sq_r[31:0], 2'b00};
      end
      S_MUL: begin
        prod_r <= root_r * {2'd0, US_PER_SEC_16};
        div_r  <= '0;
      end
      S_DIV: begin
        if (dpart >= {1'b0, step_r})
          div_r <= {20'(dpart - {1'b0, step_r}), div_r[32:0], 1'b1};
        else
          div_r <= {dpart[19:0], div_r[32:0], 1'b0};
        prod_r <= {prod_r[32:0], 1'b0};
      end
      S_FILT: begin
        raw_r   <= q;
        spd_r   <= f2;
        prev2_r <= prev_r;
        prev_r  <= q;
      end
      S_WID: begin
        est_r <= e2;
      end
      default: ;
    endcase
  end

  // the estimate is registered in WID; the width update from it is taken in DONE
  logic w_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cnt_r     <= '0;
      o_valid_r <= 1'b0;
      w_pend_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r != st_nxt) cnt_r <= '0;
      else cnt_r <= cnt_r + 6'd1;
      if (st_r == S_IDLE && job_valid) begin
        w_pend_r <= !job.first;
        if (job.first) cur_w_r <= cfg.width_floor;
      end
      if (st_r == S_DONE && (!o_valid_r || out_ready)) begin
        o_valid_r <= 1'b1;
        o_raw_r   <= raw_r;
        o_spd_r   <= spd_r;
        if (w_pend_r) begin
          o_w_r   <= w2;
          cur_w_r <= w2;
        end else begin
          o_w_r   <= cur_w_r;
        end
      end else if (out_ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = o_valid_r;
  assign raw_speed = o_raw_r;
  assign speed     = o_spd_r;
  assign width     = o_w_r;

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !job_ready) else $error("took request while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_sqrt_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_SQRT |-> cnt_r <= 6'd16) else $error("root overrun");

endmodule

// File: tb/sv/tb_stroke_speed_to_width_core.sv
// Testbench for the stroke speed to width core: scoreboard against a local width predictor.
`timescale 1ns / 100ps

module tb_stroke_speed_to_width_core;
  import sstw_pkg::*;

  typedef struct packed {
    logic [11:0] width;
    logic [15:0] speed;
    logic [19:0] raw_speed;
  } stroke_res_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [63:0]           in_tdata;   // pos_x[15:0], pos_y[31:16], time_us[63:32]
  logic                  in_tuser;   // stroke_start
  logic                  out_tvalid;
  logic                  out_tready;
  logic [47:0]           out_tdata;  // raw_speed[19:0], speed[35:20], width[47:36]
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  stroke_res_t width_expect_q[$];
  int          err_count;
  int          points_sent;
  int          results_seen;
  int          cfg_writes;
  bit          quiet;

  // predictor copy of registers and history
  cfg_t        pcfg;
  logic [15:0] hist_x;
  logic [15:0] hist_y;
  logic [31:0] hist_time;
  logic [19:0] hist_raw1;
  logic [19:0] hist_raw2;
  logic [11:0] hist_width;
  logic [1:0]  hist_count;

  stroke_speed_to_width_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned median_of3(longint unsigned a, longint unsigned b,
                                                 longint unsigned c);
    if ((a >= b && a <= c) || (a >= c && a <= b)) return a;
    if ((b >= a && b <= c) || (b >= c && b <= a)) return b;
    return c;
  endfunction

  function automatic longint unsigned bound(longint unsigned v, longint unsigned lo,
                                            longint unsigned hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic stroke_res_t stroke_width_predict(logic [15:0] x, logic [15:0] y,
                                                       logic [31:0] t, logic start);
    stroke_res_t     r;
    longint          dx;
    longint          dy;
    longint unsigned span;
    logic [31:0]     step;
    longint unsigned q;
    longint unsigned filt;
    longint unsigned spd;
    longint unsigned est;
    longint          err;
    longint          mag;
    longint          stepw;
    longint          w;
    if (start || hist_count == 2'd0) begin
      r.raw_speed = '0;
      r.speed = '0;
      w = pcfg.width_floor;
      hist_raw1 = '0;
      hist_raw2 = '0;
      hist_count = 2'd1;
    end else begin
      dx = longint'($signed(x)) - longint'($signed(hist_x));
      dy = longint'($signed(y)) - longint'($signed(hist_y));
      span = floor_root(dx * dx + dy * dy);
      step = t - hist_time;
      if (step == 0 || step[31]) step = pcfg.step_min;
      step = 32'(bound(step, pcfg.step_min, pcfg.step_max));
      if (step == 0) step = 1;
      q = (span * 62500) / step;
      r.raw_speed = (q > RAW_SPEED_SAT) ? RAW_SPEED_SAT : q[19:0];
      if (hist_count == 2'd1) filt = median_of3(r.raw_speed, r.raw_speed, hist_raw1);
      else filt = median_of3(r.raw_speed, hist_raw1, hist_raw2);
      spd = bound(filt, pcfg.speed_min, pcfg.speed_max);
      r.speed = spd[15:0];
      est = bound((spd * 64) / 25, pcfg.width_floor, pcfg.width_ceiling);
      err = longint'(est) - longint'(hist_width);
      mag = (err < 0) ? -err : err;
      w = hist_width;
      if (mag > pcfg.width_deadband) begin
        stepw = (mag * pcfg.growth_gain) >> 8;
        if (err < 0) w = (stepw > w) ? 0 : w - stepw;
        else w = w + stepw;
      end
      w = bound(w, pcfg.width_floor, pcfg.width_ceiling);
      hist_raw2 = hist_raw1;
      hist_raw1 = r.raw_speed;
      hist_count = 2'd2;
    end
    hist_width = w[11:0];
    r.width = w[11:0];
    hist_x = x;
    hist_y = y;
    hist_time = t;
    return r;
  endfunction

  always @(negedge clk) begin
    if (rst_n) out_tready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    stroke_res_t got;
    stroke_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      if (width_expect_q.size() == 0) begin
        $error("unexpected result raw_speed=%0d speed=%0d width=%0d",
               got.raw_speed, got.speed, got.width);
        err_count++;
      end else begin
        exp_r = width_expect_q.pop_front();
        if (got.raw_speed !== exp_r.raw_speed) begin
          $error("raw_speed expected %0d actual %0d", exp_r.raw_speed, got.raw_speed);
          err_count++;
        end
        if (got.speed !== exp_r.speed) begin
          $error("speed expected %0d actual %0d", exp_r.speed, got.speed);
          err_count++;
        end
        if (got.width !== exp_r.width) begin
          $error("width expected %0d actual %0d", exp_r.width, got.width);
          err_count++;
        end
      end
    end
  end

  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [31:0] t, logic start);
    int gap;
    if (!quiet && $urandom_range(0, 99) < 20) begin
      in_tvalid = 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    in_tdata = {t, y, x};
    in_tuser = start;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    width_expect_q.insert(width_expect_q.size(), stroke_width_predict(x, y, t, start));
    points_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (width_expect_q.size() != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SPEED_MIN:   pcfg.speed_min = val[15:0];
      REG_SPEED_MAX:   pcfg.speed_max = val[15:0];
      REG_STEP_MIN:    pcfg.step_min = val;
      REG_STEP_MAX:    pcfg.step_max = val;
      REG_WIDTH_FLOOR: pcfg.width_floor = val[11:0];
      REG_WIDTH_CEIL:  pcfg.width_ceiling = val[11:0];
      REG_WIDTH_DB:    pcfg.width_deadband = val[11:0];
      REG_GROWTH:      pcfg.growth_gain = val[7:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_config(logic [19:0] smin, logic [19:0] smax, logic [19:0] tmin,
                             logic [19:0] tmax, logic [19:0] wfl, logic [19:0] wce,
                             logic [19:0] wdb, logic [19:0] gain);
    wait_drained();
    write_reg(REG_SPEED_MIN, smin);
    write_reg(REG_SPEED_MAX, smax);
    write_reg(REG_STEP_MIN, tmin);
    write_reg(REG_STEP_MAX, tmax);
    write_reg(REG_WIDTH_FLOOR, wfl);
    write_reg(REG_WIDTH_CEIL, wce);
    write_reg(REG_WIDTH_DB, wdb);
    write_reg(REG_GROWTH, gain);
  endtask

  // one stroke of smooth motion with random content
  task automatic run_stroke(int n, int max_move, int max_dt);
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] t;
    x = 16'($urandom);
    y = 16'($urandom);
    t = $urandom;
    send_point(x, y, t, 1'b1);
    for (int i = 1; i < n; i++) begin
      x = 16'(x + $urandom_range(0, 2 * max_move) - max_move);
      y = 16'(y + $urandom_range(0, 2 * max_move) - max_move);
      t = t + $urandom_range(0, max_dt);
      send_point(x, y, t, 1'b0);
    end
  endtask

  task automatic test_directed();
    quiet = 1'b1;
    send_point(16'd100, 16'd200, 32'd1000, 1'b0);
    send_point(16'd260, 16'd200, 32'd11000, 1'b0);
    send_point(16'h8000, 16'h8000, 32'd16000, 1'b0);
    send_point(16'h7FFF, 16'h7FFF, 32'd16001, 1'b0);
    send_point(16'h8000, 16'h7FFF, 32'd16001, 1'b0);
    send_point(16'h8000, 16'h8000, 32'd10, 1'b0);
    send_point(16'h8000, 16'h8000, 32'hFFFF_FFF0, 1'b0);
    send_point(16'h0040, 16'h0000, 32'h0000_4000, 1'b0);
    send_point(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_point(16'h0000, 16'h0000, 32'h0010_0000, 1'b0);
    send_point(16'h0000, 16'h0000, 32'h0010_2000, 1'b0);
    quiet = 1'b0;
  endtask

  task automatic test_config_extremes();
    load_config(20'hFFFFF, 20'hFFFFF, 20'd0, 20'd0, 20'hFFFFF, 20'hFFFFF, 20'd0, 20'hFFFFF);
    run_stroke(6, 30000, 100);
    load_config(20'd0, 20'd0, 20'hFFFFF, 20'hFFFFF, 20'd0, 20'd0, 20'hFFFFF, 20'd0);
    run_stroke(6, 2000, 2000000);
    load_config(20'd5000, 20'd10, 20'd30000, 20'd2000, 20'd3000, 20'd100, 20'd0, 20'd255);
    run_stroke(6, 500, 40000);
    load_config(20'd0, 20'd65535, 20'd1, 20'd1000000, 20'd0, 20'd4095, 20'd0, 20'd128);
    run_stroke(8, 3000, 3000);
  endtask

  task automatic test_random(int total);
    int sent;
    int n;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] t;
    sent = 0;
    while (sent < total) begin
      if ((sent / 200) % 3 == 0 && sent % 200 == 0) begin
        load_config(20'($urandom_range(0, 2000)), 20'($urandom_range(500, 65535)),
                    20'($urandom_range(1, 10000)), 20'($urandom_range(5000, 1000000)),
                    20'($urandom_range(0, 400)), 20'($urandom_range(200, 4095)),
                    20'($urandom_range(0, 300)), 20'($urandom_range(0, 255)));
      end
      quiet = (sent >= 600 && sent < 800);
      if ($urandom_range(0, 19) == 0) wait_drained();
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(3, 20);
        run_stroke(n, $urandom_range(1, 4000), $urandom_range(1000, 60000));
        sent += n;
      end else begin
        x = 16'($urandom);
        y = 16'($urandom);
        t = $urandom;
        send_point(x, y, t, 1'($urandom_range(0, 1)));
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    int guard;
    err_count = 0;
    points_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    quiet = 1'b0;
    pcfg = '{16'd100, 16'd3000, 20'd5000, 20'd20000, 12'd64, 12'd2560, 12'd64, 8'd26};
    hist_x = '0;
    hist_y = '0;
    hist_time = '0;
    hist_raw1 = '0;
    hist_raw2 = '0;
    hist_width = '0;
    hist_count = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_config_extremes();
    test_random(1900);
    in_tvalid = 1'b0;
    guard = 0;
    while (width_expect_q.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (100) @(negedge clk);
    $display("Covered %0d points (directed, register extremes, random strokes and noise),",
             points_sent);
    $display("%0d results checked, %0d register writes.", results_seen, cfg_writes);
    if (err_count == 0 && width_expect_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (width_expect_q.size() != 0) $error("%0d results never arrived", width_expect_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
